@@ sv/fpc_pkg.sv @@
// fpc_pkg: shared types, constants and aes helper functions
// used by the front, keystream and back modules of frame_payload_ctr_cipher
package fpc_pkg;

  localparam int unsigned AddrW = 6;
  localparam logic [AddrW-1:0] RegKeyHigh = 6'h00;
  localparam logic [AddrW-1:0] RegKeyLow  = 6'h08;
  localparam logic [AddrW-1:0] RegDevAddr = 6'h10;
  localparam logic [AddrW-1:0] RegFrmCnt  = 6'h18;
  localparam logic [AddrW-1:0] RegDownlnk = 6'h20;
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [3:0] pos;
  } item_t;

  typedef struct packed {
    logic [127:0] key;
    logic [127:0] ctr;
  } ks_req_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_of(input logic [127:0] b, input logic [3:0] i);
    return b[8'd127 - {1'b0, i, 3'b000} -: 8];
  endfunction

  // one aes round; last round skips mixcolumns
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic fin);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8*i -: 8] = t[i];
    end
    return o ^ rk;
  endfunction

  function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, g;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    g = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ g; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ sv/frame_payload_ctr_cipher.sv @@
// frame_payload_ctr_cipher: top level, apb registers and wiring of
// front, keystream and back units; uses fpc_pkg
//
//  channel | dir | payload
//  in_     | in  | tdata[7:0] data_byte, tlast last
//  out_    | out | tdata[7:0] out_byte, tlast out_last
//  cfg_    | in  | apb, 64-bit data bus, registers at 8*i
//
// one byte per cycle inside a block while the queue has room; a block start waits
// for an empty queue and a free keystream unit, and its result shows after the
// load step, the 10 rounds and the output register
// the output register holds a result while out_tready is low, input keeps
// flowing until the two-entry queue fills
// rst_n is synchronous; config registers reset to zero, block counter to one
module frame_payload_ctr_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [63:0] kh_r, kl_r;
  logic [31:0] da_r, fc_r;
  logic        dl_r, wr;
  logic        q_push, q_full, q_empty, ks_start, ks_free, ks_done;
  fpc_pkg::item_t   q_item;
  fpc_pkg::ks_req_t ks_req;
  logic [127:0] ks_block;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_r <= '0; kl_r <= '0; da_r <= '0; fc_r <= '0; dl_r <= 1'b0;
    end else if (wr) begin
      case (cfg_paddr)
        fpc_pkg::RegKeyHigh: kh_r <= cfg_pwdata;
        fpc_pkg::RegKeyLow:  kl_r <= cfg_pwdata;
        fpc_pkg::RegDevAddr: da_r <= cfg_pwdata[31:0];
        fpc_pkg::RegFrmCnt:  fc_r <= cfg_pwdata[31:0];
        fpc_pkg::RegDownlnk: dl_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      fpc_pkg::RegKeyHigh: cfg_prdata = kh_r;
      fpc_pkg::RegKeyLow:  cfg_prdata = kl_r;
      fpc_pkg::RegDevAddr: cfg_prdata = {32'h0, da_r};
      fpc_pkg::RegFrmCnt:  cfg_prdata = {32'h0, fc_r};
      fpc_pkg::RegDownlnk: cfg_prdata = {63'h0, dl_r};
      default:             cfg_prdata = 64'h0;
    endcase
  end

  fpc_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata), .in_last(in_tlast),
    .key({kh_r, kl_r}), .node_addr(da_r), .frm_cnt(fc_r), .downlink(dl_r),
    .q_push, .q_item, .q_full, .q_empty, .ks_start, .ks_req, .ks_free
  );

  fpc_keystream u_ks (
    .clk, .rst_n, .start(ks_start), .req(ks_req), .free(ks_free), .done(ks_done),
    .block(ks_block)
  );

  fpc_back u_back (
    .clk, .rst_n, .q_push, .q_item, .q_full, .q_empty, .ks_done, .ks_block,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_tdata),
    .out_last(out_tlast)
  );
endmodule

@@ sv/fpc_front.sv @@
// fpc_front: accepts payload words, tracks position and block counter,
// pushes items to a short queue and requests keystream blocks; uses fpc_pkg
module fpc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data,
  input  logic               in_last,
  input  logic [127:0]       key,
  input  logic [31:0]        node_addr,
  input  logic [31:0]        frm_cnt,
  input  logic               downlink,
  output logic               q_push,
  output fpc_pkg::item_t     q_item,
  input  logic               q_full,
  input  logic               q_empty,
  output logic               ks_start,
  output fpc_pkg::ks_req_t   ks_req,
  input  logic               ks_free
);
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] blk_r, blk_nxt;
  logic       need;
  logic       acc;

  assign need     = (pos_r == 4'd0);
  // a block start also needs the keystream unit free to load and the queue
  // drained, since queued words still read the held block
  assign in_ready = !q_full && (!need || (ks_free && q_empty));
  assign acc      = in_valid && in_ready;
  assign q_push   = acc;
  assign q_item   = '{data: in_data, last: in_last, pos: pos_r};
  assign ks_start = acc && need;
  assign ks_req.key = key;
  assign ks_req.ctr = {8'h01, 32'h0, 7'h0, downlink, node_addr[7:0], node_addr[15:8],
                       node_addr[23:16], node_addr[31:24], frm_cnt[7:0], frm_cnt[15:8],
                       frm_cnt[23:16], frm_cnt[31:24], 8'h00, blk_r};

  always_comb begin
    pos_nxt = pos_r;
    blk_nxt = blk_r;
    if (acc) begin
      if (in_last) begin
        pos_nxt = 4'd0;
        blk_nxt = 8'd1;
      end else begin
        pos_nxt = pos_r + 4'd1;
        if (pos_r == 4'd15) blk_nxt = blk_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 4'd0;
      blk_r <= 8'd1;
    end else begin
      pos_r <= pos_nxt;
      blk_r <= blk_nxt;
    end
  end

  a_blk_start: assert property (@(posedge clk) disable iff (!rst_n)
    ks_start |-> q_item.pos == 4'd0) else $error("block start off position zero");
  a_last_reset: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_last |=> pos_r == 4'd0 && blk_r == 8'd1) else $error("frame restart missed");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !acc) else $error("push into full queue");
  a_start_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ks_start |-> q_empty) else $error("block start with words queued");
endmodule

@@ sv/fpc_keystream.sv @@
// fpc_keystream: iterative aes-128, one round per cycle, a load step then 10 rounds per block
// holds the finished block until the next start; uses fpc_pkg
module fpc_keystream (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fpc_pkg::ks_req_t req,
  output logic             free,
  output logic             done,
  output logic [127:0]     block
);
  logic [127:0] st_r, st_nxt, rk_r, rk_nxt, nrk;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic         busy_r, busy_nxt;

  assign free  = !busy_r;
  assign done  = !busy_r;
  assign block = st_r;
  assign nrk   = fpc_pkg::next_rkey(rk_r, rc_r);

  always_comb begin
    st_nxt = st_r; rk_nxt = rk_r; rnd_nxt = rnd_r; rc_nxt = rc_r; busy_nxt = busy_r;
    if (start) begin
      st_nxt = req.ctr ^ req.key;
      rk_nxt = req.key;
      rnd_nxt = 4'd1;
      rc_nxt = 8'h01;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt = fpc_pkg::aes_round(st_r, nrk, rnd_r == 4'd10);
      rk_nxt = nrk;
      rc_nxt = fpc_pkg::xtime(rc_r);
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == 4'd10) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
    end
    st_r <= st_nxt;
    rk_r <= rk_nxt;
    rc_r <= rc_nxt;
  end

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("start while busy");
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r >= 4'd1 && rnd_r <= 4'd10) else $error("round out of range");
endmodule

@@ sv/fpc_back.sv @@
// fpc_back: item queue plus xor stage and output register
// pops an item once its keystream block is ready; uses fpc_pkg
module fpc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  fpc_pkg::item_t q_item,
  output logic           q_full,
  output logic           q_empty,
  input  logic           ks_done,
  input  logic [127:0]   ks_block,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_data,
  output logic           out_last
);
  fpc_pkg::item_t q_r [fpc_pkg::QDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       pop, ov_r;
  logic [7:0] od_r;
  logic       ol_r;
  fpc_pkg::item_t head;

  assign head    = q_r[rp_r];
  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  // a block start item waits for the round loop; later items of the block
  // are behind it and the block stays held until the next start
  assign pop    = (cnt_r != 2'd0) && ks_done && (!ov_r || out_ready);
  assign cnt_nxt = cnt_r + {1'b0, q_push} - {1'b0, pop};

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_last  = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      if (pop) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (q_push) q_r[wp_r] <= q_item;
    if (pop) begin
      od_r <= head.data ^ fpc_pkg::byte_of(ks_block, head.pos);
      ol_r <= head.last;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(od_r)) else $error("result dropped");
endmodule

@@ tb/sv/testbench.sv @@
// testbench for frame_payload_ctr_cipher: aes-128 counter mode keystream predictor,
// apb register writes, random stream stimulus with stalls; depends on fpc_pkg and the rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tlast = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic in_tready;
  logic out_tvalid, out_tlast;
  logic [7:0] out_tdata;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [5:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  always #4 clk = ~clk;

  frame_payload_ctr_cipher dut (.*);

  typedef struct {
    logic [7:0] byte_val;
    logic       last;
  } cipher_word_t;

  cipher_word_t expected_words[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;

  // predictor state
  logic [63:0] m_key_high = '0, m_key_low = '0;
  logic [31:0] m_node_addr = '0, m_frm_cnt = '0;
  logic m_downlink = 1'b0;
  logic [7:0] m_ks [16];
  logic [3:0] m_pos = '0;
  logic [7:0] m_blk = 8'd1;

  logic [7:0] sb [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte-array aes-128 encryption of the counter block into m_ks
  task automatic refresh_keystream();
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] w0, w1, w2, w3, sw, a0, a1, a2, a3, al;
    logic [7:0] rc;
    for (int i = 0; i < 8; i++) begin
      rk[i] = m_key_high[63-8*i -: 8];
      rk[8+i] = m_key_low[63-8*i -: 8];
    end
    rc = 8'h01;
    for (int i = 16; i < 176; i += 4) begin
      w0 = rk[i-4]; w1 = rk[i-3]; w2 = rk[i-2]; w3 = rk[i-1];
      if (i % 16 == 0) begin
        sw = w0;
        w0 = sb[w1] ^ rc; w1 = sb[w2]; w2 = sb[w3]; w3 = sb[sw];
        rc = gf_double(rc);
      end
      rk[i] = rk[i-16] ^ w0; rk[i+1] = rk[i-15] ^ w1;
      rk[i+2] = rk[i-14] ^ w2; rk[i+3] = rk[i-13] ^ w3;
    end
    for (int i = 0; i < 16; i++) st[i] = 8'h00;
    st[0] = 8'h01;
    st[5] = {7'd0, m_downlink};
    for (int i = 0; i < 4; i++) begin
      st[6+i] = m_node_addr[8*i +: 8];
      st[10+i] = m_frm_cnt[8*i +: 8];
    end
    st[15] = m_blk;
    for (int i = 0; i < 16; i++) st[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) tmp[w + 4*c] = sb[st[w + 4*((c + w) % 4)]];
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c] = a0 ^ al ^ gf_double(a0 ^ a1);
          tmp[4*c+1] = a1 ^ al ^ gf_double(a1 ^ a2);
          tmp[4*c+2] = a2 ^ al ^ gf_double(a2 ^ a3);
          tmp[4*c+3] = a3 ^ al ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*r + i];
    end
    for (int i = 0; i < 16; i++) m_ks[i] = st[i];
  endtask

  task automatic predict_word(logic [7:0] d, logic l);
    cipher_word_t w;
    if (m_pos == 0) refresh_keystream();
    w.byte_val = d ^ m_ks[m_pos];
    w.last = l;
    expected_words = {expected_words, w};
    if (l) begin
      m_pos = '0;
      m_blk = 8'd1;
    end else begin
      m_pos = m_pos + 1'b1;
      if (m_pos == 0) m_blk = m_blk + 1'b1;
    end
  endtask

  // valid stays high between words; idling and drain drop it
  task automatic send_word(logic [7:0] d, logic l);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= l;
    predict_word(d, l);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(logic [5:0] addr, logic [63:0] value);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (addr)
      fpc_pkg::RegKeyHigh: m_key_high = value;
      fpc_pkg::RegKeyLow:  m_key_low = value;
      fpc_pkg::RegDevAddr: m_node_addr = value[31:0];
      fpc_pkg::RegFrmCnt:  m_frm_cnt = value[31:0];
      fpc_pkg::RegDownlnk: m_downlink = value[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int guard = 0;
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic setup_regs(logic [63:0] kh, logic [63:0] kl, logic [31:0] da,
                            logic [31:0] fc, logic dl);
    drain();
    write_reg(fpc_pkg::RegKeyHigh, kh);
    write_reg(fpc_pkg::RegKeyLow, kl);
    write_reg(fpc_pkg::RegDevAddr, {$urandom, da});
    write_reg(fpc_pkg::RegFrmCnt, {$urandom, fc});
    write_reg(fpc_pkg::RegDownlnk, {$urandom, $urandom} & ~64'h1 | {63'h0, dl});
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  // extremes of the byte in single-byte frames, a 17-byte frame across a block boundary and a two-byte frame
  task automatic test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    send_word(8'h00, 1'b1);
    send_word(8'hff, 1'b1);
    for (int i = 0; i < 17; i++) send_word(i[0] ? 8'hff : 8'h00, i == 16);
    send_word(8'ha5, 1'b0);
    send_word(8'h5a, 1'b1);
  endtask

  task automatic test_random(int n, int idle, int stall);
    int len;
    send_idle_pct = idle; recv_stall_pct = stall;
    while (n > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(20, 1);
      for (int i = 0; i < len; i++) send_word($urandom_range(255), i == len - 1);
      n -= len;
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 40; i++) send_word($urandom_range(255), i == 39);
      end
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  always @(posedge clk) begin
    cipher_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: byte %h last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_tdata !== w.byte_val) begin
          $error("out_byte expected %h actual %h", w.byte_val, out_tdata);
          errors++;
        end
        if (out_tlast !== w.last) begin
          $error("out_last expected %b actual %b", w.last, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= !hold_off && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    setup_regs('1, '1, '1, '1, 1'b1);
    test_directed();
    setup_regs({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, 1'b1);
    test_backpressure();
    test_random(450, 0, 0);
    setup_regs({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, 1'b0);
    test_random(450, 51, 0);
    setup_regs('0, '0, '0, '0, 1'b0);
    test_random(450, 0, 51);
    setup_regs({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, 1'b1);
    test_random(450, 38, 38);
    drain();
    if (errors == 0 && expected_words.size() == 0) begin
      $display("frame_payload_ctr_cipher test passed");
    end else begin
      $display("frame_payload_ctr_cipher test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("frame_payload_ctr_cipher test failed");
    $finish;
  end
endmodule

@@ files.f @@
sv/fpc_pkg.sv
sv/fpc_front.sv
sv/fpc_keystream.sv
sv/fpc_back.sv
sv/frame_payload_ctr_cipher.sv
tb/sv/testbench.sv
